[design/cps_pkg.sv]
// Shared types, sizes and rounding helpers for the circle push-out pipeline.
package cps_pkg;

  localparam int unsigned NORM_ONE   = 16384;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned FRONT_LAT  = 3;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 1;
  localparam int unsigned BACK_LAT   = 4;

  typedef enum logic [1:0] {
    REG_FIRST_RADIUS  = 2'd0,
    REG_SECOND_RADIUS = 2'd1
  } cps_reg_e;

  typedef struct packed {
    logic signed [31:0] first_end_a_x;
    logic signed [31:0] first_end_a_z;
    logic signed [31:0] first_end_b_x;
    logic signed [31:0] first_end_b_z;
    logic signed [31:0] second_end_a_x;
    logic signed [31:0] second_end_a_z;
    logic signed [31:0] second_end_b_x;
    logic signed [31:0] second_end_b_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_z;
  } cps_in_t;

  // per-item values that ride alongside the square root and divider
  typedef struct packed {
    logic               hit;
    logic               zero;
    logic               neg_x;
    logic               neg_z;
    logic [31:0]        ax;
    logic [31:0]        az;
    logic [31:0]        r;
    logic signed [31:0] vx;
    logic signed [31:0] vz;
  } cps_side_t;

  typedef struct packed {
    cps_side_t   side;
    logic [31:0] d;
    logic [32:0] den;
    logic [47:0] rem_x;
    logic [47:0] rem_z;
    logic [14:0] q_x;
    logic [14:0] q_z;
  } cps_div_t;

  // divide by 2^s, rounded half away from zero
  function automatic logic signed [65:0] shr_round(logic signed [65:0] v, int unsigned s);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[design/cps_front.sv]
// Centre offsets, squares and overlap test: three register stages.
module cps_front import cps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cps_in_t     in_i,
  input  logic [30:0] r1_i,
  input  logic [30:0] r2_i,
  output logic        valid_o,
  output cps_side_t   side_o,
  output logic [63:0] d2_o
);

  logic [FRONT_LAT-1:0] v_q;

  logic signed [34:0] ddx, ddz;
  logic [34:0]        mx, mz;
  logic [32:0]        ax1_q, az1_q, ax1_d, az1_d;
  logic               nx1_q, nz1_q;
  logic [31:0]        r1_q, r_d;
  logic signed [31:0] vx1_q, vz1_q;

  logic               ltx2_q, ltz2_q;
  logic [63:0]        x2_q, z2_q, rr2_q;
  logic [31:0]        ax2_q, az2_q, r2_q;
  logic               nx2_q, nz2_q;
  logic signed [31:0] vx2_q, vz2_q;

  function automatic logic signed [34:0] sx(logic signed [31:0] a);
    return {{3{a[31]}}, a};
  endfunction

  always_comb begin
    ddx   = (sx(in_i.first_end_a_x) + sx(in_i.first_end_b_x))
          - (sx(in_i.second_end_a_x) + sx(in_i.second_end_b_x));
    ddz   = (sx(in_i.first_end_a_z) + sx(in_i.first_end_b_z))
          - (sx(in_i.second_end_a_z) + sx(in_i.second_end_b_z));
    mx    = ddx[34] ? 35'(-ddx) : 35'(ddx);
    mz    = ddz[34] ? 35'(-ddz) : 35'(ddz);
    ax1_d = mx[33:1];
    az1_d = mz[33:1];
    r_d   = {1'b0, r1_i} + {1'b0, r2_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FRONT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= ax1_d;
      az1_q  <= az1_d;
      nx1_q  <= ddx[34];
      nz1_q  <= ddz[34];
      r1_q   <= r_d;
      vx1_q  <= in_i.vel_x;
      vz1_q  <= in_i.vel_z;

      ltx2_q <= ax1_q < {1'b0, r1_q};
      ltz2_q <= az1_q < {1'b0, r1_q};
      x2_q   <= ax1_q[31:0] * ax1_q[31:0];
      z2_q   <= az1_q[31:0] * az1_q[31:0];
      rr2_q  <= r1_q * r1_q;
      ax2_q  <= ax1_q[31:0];
      az2_q  <= az1_q[31:0];
      r2_q   <= r1_q;
      nx2_q  <= nx1_q;
      nz2_q  <= nz1_q;
      vx2_q  <= vx1_q;
      vz2_q  <= vz1_q;

      side_o.hit   <= ltx2_q && ltz2_q && (({1'b0, x2_q} + {1'b0, z2_q}) < {1'b0, rr2_q});
      side_o.zero  <= (x2_q == '0) && (z2_q == '0);
      side_o.neg_x <= nx2_q;
      side_o.neg_z <= nz2_q;
      side_o.ax    <= ax2_q;
      side_o.az    <= az2_q;
      side_o.r     <= r2_q;
      side_o.vx    <= vx2_q;
      side_o.vz    <= vz2_q;
      d2_o         <= x2_q + z2_q;
    end
  end

  assign valid_o = v_q[FRONT_LAT-1];

endmodule

[design/cps_sqrt.sv]
// Integer square root of the squared distance, one result bit per stage.
module cps_sqrt import cps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cps_side_t   side_i,
  input  logic [63:0] d2_i,
  output logic        valid_o,
  output cps_side_t   side_o,
  output logic [31:0] d_o
);

  logic [63:0] rem_q  [SQRT_STEPS];
  logic [63:0] res_q  [SQRT_STEPS];
  cps_side_t   side_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] v_q;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [63:0] rem_in, res_in, rem_d, res_d;
    cps_side_t   side_in;
    logic        v_in;

    if (j == 0) begin : g_first
      assign rem_in  = d2_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign res_in  = res_q[j-1];
      assign side_in = side_q[j-1];
      assign v_in    = v_q[j-1];
    end

    always_comb begin
      if (rem_in >= res_in + Bit) begin
        rem_d = rem_in - (res_in + Bit);
        res_d = (res_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        res_q[j]  <= res_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];
  assign d_o     = res_q[SQRT_STEPS-1][31:0];

endmodule

[design/cps_div.sv]
// Two restoring dividers for the normal components, one quotient bit per stage.
module cps_div import cps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cps_side_t   side_i,
  input  logic [31:0] d_i,
  output logic        valid_o,
  output cps_div_t    div_o
);

  cps_div_t          st_q [DIV_LAT];
  logic [DIV_LAT-1:0] v_q;

  // n * 2 * NORM_ONE + d over 2d gives the rounded quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].side  <= side_i;
      st_q[0].d     <= d_i;
      st_q[0].den   <= {d_i, 1'b0};
      st_q[0].rem_x <= {1'b0, side_i.ax, 15'd0} + {16'd0, d_i};
      st_q[0].rem_z <= {1'b0, side_i.az, 15'd0} + {16'd0, d_i};
      st_q[0].q_x   <= '0;
      st_q[0].q_z   <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_LAT-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int unsigned Pos = DIV_STEPS - 1 - j;
    cps_div_t    st_d;
    logic [47:0] trial;

    always_comb begin
      st_d  = st_q[j];
      trial = {15'd0, st_q[j].den} << Pos;
      if (st_q[j].rem_x >= trial) begin
        st_d.rem_x    = st_q[j].rem_x - trial;
        st_d.q_x[Pos] = 1'b1;
      end
      if (st_q[j].rem_z >= trial) begin
        st_d.rem_z    = st_q[j].rem_z - trial;
        st_d.q_z[Pos] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j+1] <= st_d;
      end
    end
  end

  assign valid_o = v_q[DIV_LAT-1];
  assign div_o   = st_q[DIV_LAT-1];

endmodule

[design/cps_back.sv]
// Normal, push and velocity slide: four register stages ending in the output beat.
module cps_back import cps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cps_div_t           div_i,
  output logic               valid_o,
  output logic               overlap_o,
  output logic signed [31:0] push_x_o,
  output logic signed [31:0] push_z_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_z_o
);

  logic [BACK_LAT-1:0] v_q;

  logic signed [15:0] nxa_d, nza_d, nxa_q, nza_q;
  logic [31:0]        pena_q;
  logic               hita_q;
  logic signed [31:0] vxa_q, vza_q;

  logic signed [48:0] ppx_q, ppz_q, vn_q;
  logic signed [15:0] nxb_q, nzb_q;
  logic               hitb_q;
  logic signed [31:0] vxb_q, vzb_q;

  logic signed [31:0] pxc_q, pzc_q;
  logic signed [64:0] mx_q, mz_q;
  logic               slide_q;
  logic signed [15:0] nxc_q, nzc_q;
  logic               hitc_q;
  logic signed [31:0] vxc_q, vzc_q;

  logic signed [65:0] tx, tz;

  function automatic logic signed [15:0] comp(logic [14:0] q, logic neg);
    logic [15:0] m;
    m = (q > 15'(NORM_ONE)) ? 16'(NORM_ONE) : {1'b0, q};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    if (!div_i.side.hit) begin
      nxa_d = '0;
      nza_d = '0;
    end else if (div_i.side.zero) begin
      nxa_d = 16'(NORM_ONE);
      nza_d = '0;
    end else begin
      nxa_d = comp(div_i.q_x, div_i.side.neg_x);
      nza_d = comp(div_i.q_z, div_i.side.neg_z);
    end
    tx = ({{34{vxc_q[31]}}, vxc_q} <<< 28) - {mx_q[64], mx_q};
    tz = ({{34{vzc_q[31]}}, vzc_q} <<< 28) - {mz_q[64], mz_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[BACK_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxa_q   <= nxa_d;
      nza_q   <= nza_d;
      pena_q  <= div_i.side.r - div_i.d;
      hita_q  <= div_i.side.hit;
      vxa_q   <= div_i.side.vx;
      vza_q   <= div_i.side.vz;

      ppx_q   <= 49'(nxa_q * $signed({1'b0, pena_q}));
      ppz_q   <= 49'(nza_q * $signed({1'b0, pena_q}));
      vn_q    <= 49'(vxa_q * nxa_q) + 49'(vza_q * nza_q);
      nxb_q   <= nxa_q;
      nzb_q   <= nza_q;
      hitb_q  <= hita_q;
      vxb_q   <= vxa_q;
      vzb_q   <= vza_q;

      pxc_q   <= sat32(shr_round(66'(ppx_q), 14));
      pzc_q   <= sat32(shr_round(66'(ppz_q), 14));
      mx_q    <= 65'(vn_q * nxb_q);
      mz_q    <= 65'(vn_q * nzb_q);
      slide_q <= hitb_q && vn_q[48];
      nxc_q   <= nxb_q;
      nzc_q   <= nzb_q;
      hitc_q  <= hitb_q;
      vxc_q   <= vxb_q;
      vzc_q   <= vzb_q;

      overlap_o   <= hitc_q;
      push_x_o    <= pxc_q;
      push_z_o    <= pzc_q;
      normal_x_o  <= nxc_q;
      normal_z_o  <= nzc_q;
      new_vel_x_o <= slide_q ? sat32(shr_round(tx, 28)) : vxc_q;
      new_vel_z_o <= slide_q ? sat32(shr_round(tz, 28)) : vzc_q;
    end
  end

  assign valid_o = v_q[BACK_LAT-1];

endmodule

[design/circle_pushout_slide_xz_top.sv]
// Top level of the XZ circle push-out and velocity slide pipeline.
// One beat is accepted every cycle unless the output beat is held; each beat passes
// through 3 front stages, 32 square-root stages, 16 divider stages and 4 back stages.
// The whole pipeline advances together: when the output beat is held, input
// tready drops and every stage holds. Radii are written through the config
// channel, which is always ready; write them only while the pipeline is empty.
module circle_pushout_slide_xz_top import cps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_end_a_x, first_end_a_z, first_end_b_x, first_end_b_z, second_end_a_x,
  // second_end_a_z, second_end_b_x, second_end_b_z, vel_x, vel_z (32 bits each)
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // push_x, push_z (32), normal_x, normal_z (16), new_vel_x, new_vel_z (32)
  output logic [159:0] m_axis_tdata,
  // overlap
  output logic         m_axis_tuser
);

  logic [30:0] r1_q, r2_q;
  logic        en;
  cps_in_t     in;

  logic        f_valid, s_valid, d_valid;
  cps_side_t   f_side, s_side;
  logic [63:0] f_d2;
  logic [31:0] s_d;
  cps_div_t    d_div;

  logic signed [31:0] push_x, push_z, nvel_x, nvel_z;
  logic signed [15:0] norm_x, norm_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= 31'd65536;
      r2_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_FIRST_RADIUS:  r1_q <= cfg_data_i[30:0];
        REG_SECOND_RADIUS: r2_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // advance unless the output beat is stuck
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign in.first_end_a_x  = s_axis_tdata[31:0];
  assign in.first_end_a_z  = s_axis_tdata[63:32];
  assign in.first_end_b_x  = s_axis_tdata[95:64];
  assign in.first_end_b_z  = s_axis_tdata[127:96];
  assign in.second_end_a_x = s_axis_tdata[159:128];
  assign in.second_end_a_z = s_axis_tdata[191:160];
  assign in.second_end_b_x = s_axis_tdata[223:192];
  assign in.second_end_b_z = s_axis_tdata[255:224];
  assign in.vel_x          = s_axis_tdata[287:256];
  assign in.vel_z          = s_axis_tdata[319:288];

  cps_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .in_i(in),
    .r1_i(r1_q), .r2_i(r2_q), .valid_o(f_valid), .side_o(f_side), .d2_o(f_d2)
  );

  cps_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .side_i(f_side), .d2_i(f_d2),
    .valid_o(s_valid), .side_o(s_side), .d_o(s_d)
  );

  cps_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_valid), .side_i(s_side), .d_i(s_d),
    .valid_o(d_valid), .div_o(d_div)
  );

  cps_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .div_i(d_div),
    .valid_o(m_axis_tvalid), .overlap_o(m_axis_tuser),
    .push_x_o(push_x), .push_z_o(push_z),
    .normal_x_o(norm_x), .normal_z_o(norm_z),
    .new_vel_x_o(nvel_x), .new_vel_z_o(nvel_z)
  );

  assign m_axis_tdata = {nvel_z, nvel_x, norm_z, norm_x, push_z, push_x};

endmodule
